@@ rtl/b64d_pkg.sv @@
// Shared types, status codes and the character classifier for the base64 decoder.
// No dependencies; every other file in rtl imports this package.
package b64d_pkg;

	// final status codes, reported with the last result of a string
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CHAR  = 3'd1,
		ST_AFTER_PAD = 3'd2,
		ST_MANY_PADS = 3'd3,
		ST_BAD_LEN   = 3'd4
	} status_t;

	// one encoded character
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	// one result
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       done_res;
		status_t    status;
	} out_item_t;

	// all results made by one character, res[0] goes out first
	typedef struct packed {
		logic [1:0]            cnt;
		out_item_t [2:0]       res;
	} b64d_bundle_t;

	// class of one character
	typedef struct packed {
		logic       is_pad;
		logic       is_bad;
		logic [5:0] val;
	} sym_t;

	localparam logic [7:0] CH_PAD = 8'h3D;

	// alphabet lookup, standard or url-safe
	function automatic sym_t b64d_classify(input logic [7:0] c, input logic safe);
		sym_t s;
		s = '{is_pad: 1'b0, is_bad: 1'b0, val: 6'd0};
		if (c inside {["A":"Z"]}) begin
			s.val = 6'(c - 8'h41);
		end else if (c inside {["a":"z"]}) begin
			s.val = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {["0":"9"]}) begin
			s.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == CH_PAD) begin
			s.is_pad = 1'b1;
		end else if (safe && c == 8'h2D) begin
			s.val = 6'd62;
		end else if (safe && c == 8'h5F) begin
			s.val = 6'd63;
		end else if (!safe && c == 8'h2B) begin
			s.val = 6'd62;
		end else if (!safe && c == 8'h2F) begin
			s.val = 6'd63;
		end else begin
			s.is_bad = 1'b1;
		end
		return s;
	endfunction

endpackage

@@ rtl/b64d_core.sv @@
// Decode state and per-character logic: turns one character into 0 to 3 results.
// Depends on b64d_pkg.
module b64d_core
	import b64d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         url_safe,
	input  in_item_t     item,
	input  logic         fire,
	output b64d_bundle_t bundle
);

	logic [17:0] group_q;
	logic [1:0]  pos_q;
	logic [1:0]  pad_q;
	status_t     err_q;

	logic [17:0] group_d;
	logic [1:0]  pos_d;
	logic [1:0]  pad_d;
	status_t     err_d;

	// decode one character
	always_comb begin
		sym_t        s;
		logic [1:0]  n;
		logic [23:0] w;
		logic [2:0]  fill;
		status_t     st;
		s       = b64d_classify(item.ch, url_safe);
		n       = 2'd0;
		w       = {group_q, s.val};
		fill    = 3'(pos_q) + 3'(pad_q);
		st      = ST_OK;
		group_d = group_q;
		pos_d   = pos_q;
		pad_d   = pad_q;
		err_d   = err_q;
		bundle  = '0;
		// scan while no error is held
		if (err_q == ST_OK) begin
			if (s.is_bad) begin
				err_d = ST_BAD_CHAR;
			end else if (s.is_pad) begin
				if (pad_q == 2'd0) begin
					if (pos_q == 2'd2) begin
						bundle.res[0] = '{group_q[11:4], 1'b1, 1'b0, ST_OK};
						n = 2'd1;
					end else if (pos_q == 2'd3) begin
						bundle.res[0] = '{group_q[17:10], 1'b1, 1'b0, ST_OK};
						bundle.res[1] = '{group_q[9:2], 1'b1, 1'b0, ST_OK};
						n = 2'd2;
					end
				end
				if (pad_q != 2'd3) begin
					pad_d = pad_q + 2'd1;
				end
			end else if (pad_q != 2'd0) begin
				err_d = ST_AFTER_PAD;
			end else if (pos_q == 2'd3) begin
				bundle.res[0] = '{w[23:16], 1'b1, 1'b0, ST_OK};
				bundle.res[1] = '{w[15:8], 1'b1, 1'b0, ST_OK};
				bundle.res[2] = '{w[7:0], 1'b1, 1'b0, ST_OK};
				n = 2'd3;
				group_d = '0;
				pos_d = 2'd0;
			end else begin
				group_d = {group_q[11:0], s.val};
				pos_d = pos_q + 2'd1;
			end
		end
		// end of string: flush an unpadded group and attach the status
		if (item.last) begin
			if (err_d == ST_OK && pad_d == 2'd0) begin
				if (pos_d == 2'd2) begin
					bundle.res[0] = '{group_d[11:4], 1'b1, 1'b0, ST_OK};
					n = 2'd1;
				end else if (pos_d == 2'd3) begin
					bundle.res[0] = '{group_d[17:10], 1'b1, 1'b0, ST_OK};
					bundle.res[1] = '{group_d[9:2], 1'b1, 1'b0, ST_OK};
					n = 2'd2;
				end
			end
			fill = 3'(pos_d) + 3'(pad_d);
			if (err_d != ST_OK) begin
				st = err_d;
			end else if (pad_d == 2'd3) begin
				st = ST_MANY_PADS;
			end else if (pad_d != 2'd0) begin
				if (pos_d < 2'd2 || (!url_safe && fill != 3'd4)) begin
					st = ST_BAD_LEN;
				end
			end else if (pos_d == 2'd1 || (!url_safe && pos_d != 2'd0)) begin
				st = ST_BAD_LEN;
			end
			if (n == 2'd0) begin
				n = 2'd1;
			end
			bundle.res[n - 2'd1].done_res = 1'b1;
			bundle.res[n - 2'd1].status   = st;
			group_d = '0;
			pos_d   = 2'd0;
			pad_d   = 2'd0;
			err_d   = ST_OK;
		end
		bundle.cnt = n;
	end

	// group payload
	always_ff @(posedge clk) begin
		if (fire) begin
			group_q <= group_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			pad_q <= 2'd0;
			err_q <= ST_OK;
		end else if (fire) begin
			pos_q <= pos_d;
			pad_q <= pad_d;
			err_q <= err_d;
		end
	end

endmodule

@@ rtl/b64d_obuf.sv @@
// Result register: holds one character's results and sends them one per cycle while not stalled.
// Depends on b64d_pkg.
module b64d_obuf
	import b64d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  b64d_bundle_t bundle,
	output logic         free,
	output logic         out_valid,
	input  logic         out_stall,
	output out_item_t    out_item
);

	out_item_t [2:0] res_q;
	logic [1:0]      rem_q;
	logic            pop;

	assign out_valid = (rem_q != 2'd0);
	assign out_item  = res_q[0];
	assign pop       = out_valid && !out_stall;
	// free for a new bundle when empty or its final item leaves now
	assign free      = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);

	// result payload, shifted toward slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle.res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	// remaining item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= bundle.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

endmodule

@@ rtl/base64_decoder_with_validation.sv @@
// Streaming base64 decoder with validation, standard or url-safe alphabet.
// One character is taken per cycle while in_stall is low; it is registered, then
// decoded, and its results (0 to 3) land in a result register once that register
// is free. Results leave one per cycle while out_stall is low, so a character that
// completes a group (three bytes) holds the input until its last byte leaves. The
// result register sets this limit. The status is valid only on the item with
// done_res set, and bytes of a string whose status is not zero must be discarded.
// Depends on b64d_pkg.
module base64_decoder_with_validation
	import b64d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic         url_safe_q;
	logic         valid_s1;
	in_item_t     item_s1;
	logic         free;
	logic         adv_s1;
	b64d_bundle_t bundle;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_safe_q <= 1'b0;
		end else if (cfg_we) begin
			url_safe_q <= cfg_wdata;
		end
	end

	// input stage
	assign adv_s1   = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	b64d_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.url_safe (url_safe_q),
		.item     (item_s1),
		.fire     (adv_s1),
		.bundle   (bundle)
	);

	b64d_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// an item without a byte only ever closes a string
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.byte_valid |-> out_item.done_res)
		else $error("result without byte that is not final");

	// status is zero except on the final item
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.done_res |-> out_item.status == ST_OK)
		else $error("status set on a non-final item");

	// a character moving on always makes a result when it is last
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.last |-> bundle.cnt != 2'd0)
		else $error("last character made no result");

	// input is held back only while the input stage is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with nothing pending");

endmodule
